FILE: rtl/psd_pkg.sv
// psd_pkg: widths, beat types and pipeline record types of the
// point to segment distance block; no dependencies
package psd_pkg;

	localparam int COORD_WIDTH     = 24;
	localparam int COORD_FRAC_BITS = 8;
	localparam int T_FRAC_BITS     = 16;

	localparam int DIFF_W  = COORD_WIDTH + 1;        // b-a, p-a
	localparam int PROD_W  = 2 * DIFF_W;             // one product term
	localparam int L2_W    = PROD_W + 1;             // sum of three squares
	localparam int DOT_W   = PROD_W + 2;             // signed sum of three
	localparam int T_W     = T_FRAC_BITS + 1;        // t in [0,1]
	localparam int OFFP_W  = T_W + 1 + DIFF_W;       // t*d product
	localparam int ERR_W   = DIFF_W + 1;             // w - offset
	localparam int SQ_W    = 2 * ERR_W + 2;          // sum of squared errors
	localparam int ROOT_W  = SQ_W / 2;
	localparam int REM_W   = ROOT_W + 2;
	localparam int DIST_W  = 26;

	typedef struct packed {
		logic [COORD_WIDTH-1:0] seg_a_x;
		logic [COORD_WIDTH-1:0] seg_a_y;
		logic [COORD_WIDTH-1:0] seg_a_z;
		logic [COORD_WIDTH-1:0] seg_b_x;
		logic [COORD_WIDTH-1:0] seg_b_y;
		logic [COORD_WIDTH-1:0] seg_b_z;
		logic [COORD_WIDTH-1:0] query_x;
		logic [COORD_WIDTH-1:0] query_y;
		logic [COORD_WIDTH-1:0] query_z;
	} psd_in_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              degenerate;
	} psd_out_t;

	// record handed along the divider cells
	typedef struct packed {
		logic [2:0][DIFF_W-1:0] w;
		logic [2:0][DIFF_W-1:0] d;
		logic [L2_W-1:0]        l2;
		logic [L2_W-1:0]        r;
		logic [T_W-1:0]         t;
		logic                   run;
		logic                   degen;
	} psd_div_t;

	// record handed along the square root cells
	typedef struct packed {
		logic [SQ_W-1:0]   n;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic              degen;
	} psd_sqrt_t;

endpackage

FILE: rtl/psd_front.sv
// psd_front: differences, products and sums ahead of the divider chain,
// three stages; depends on psd_pkg
module psd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  psd_pkg::psd_in_t   in_data,
	output logic               in_ready,
	output logic               out_valid,
	output psd_pkg::psd_div_t  out_data,
	input  logic               out_ready
);

	localparam int DW = psd_pkg::DIFF_W;
	localparam int PW = psd_pkg::PROD_W;

	logic valid_s1, valid_s2, valid_s3;
	logic ready_s1, ready_s2, ready_s3;

	logic signed [DW-1:0] d_s1 [3];
	logic signed [DW-1:0] w_s1 [3];
	logic signed [DW-1:0] d_s2 [3];
	logic signed [DW-1:0] w_s2 [3];
	logic signed [PW-1:0] dd_s2 [3];
	logic signed [PW-1:0] wd_s2 [3];
	psd_pkg::psd_div_t    rec_s3;

	logic signed [DW-1:0] a_c [3];
	logic signed [DW-1:0] b_c [3];
	logic signed [DW-1:0] p_c [3];
	logic [psd_pkg::L2_W-1:0]         l2_c;
	logic signed [psd_pkg::DOT_W-1:0] dot_c;
	psd_pkg::psd_div_t                rec_c;

	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_comb begin
		a_c[0] = $signed({in_data.seg_a_x[psd_pkg::COORD_WIDTH-1], in_data.seg_a_x});
		a_c[1] = $signed({in_data.seg_a_y[psd_pkg::COORD_WIDTH-1], in_data.seg_a_y});
		a_c[2] = $signed({in_data.seg_a_z[psd_pkg::COORD_WIDTH-1], in_data.seg_a_z});
		b_c[0] = $signed({in_data.seg_b_x[psd_pkg::COORD_WIDTH-1], in_data.seg_b_x});
		b_c[1] = $signed({in_data.seg_b_y[psd_pkg::COORD_WIDTH-1], in_data.seg_b_y});
		b_c[2] = $signed({in_data.seg_b_z[psd_pkg::COORD_WIDTH-1], in_data.seg_b_z});
		p_c[0] = $signed({in_data.query_x[psd_pkg::COORD_WIDTH-1], in_data.query_x});
		p_c[1] = $signed({in_data.query_y[psd_pkg::COORD_WIDTH-1], in_data.query_y});
		p_c[2] = $signed({in_data.query_z[psd_pkg::COORD_WIDTH-1], in_data.query_z});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= b_c[i] - a_c[i];
				w_s1[i] <= p_c[i] - a_c[i];
			end
		end
		if (ready_s2 && valid_s1) begin
			for (int i = 0; i < 3; i++) begin
				d_s2[i]  <= d_s1[i];
				w_s2[i]  <= w_s1[i];
				dd_s2[i] <= d_s1[i] * d_s1[i];
				wd_s2[i] <= w_s1[i] * d_s1[i];
			end
		end
		if (ready_s3 && valid_s2) rec_s3 <= rec_c;
	end

	always_comb begin
		l2_c  = '0;
		dot_c = '0;
		for (int i = 0; i < 3; i++) begin
			l2_c  = l2_c + psd_pkg::L2_W'($unsigned(dd_s2[i]));
			dot_c = dot_c + psd_pkg::DOT_W'(wd_s2[i]);
		end
		for (int i = 0; i < 3; i++) begin
			rec_c.w[i] = w_s2[i];
			rec_c.d[i] = d_s2[i];
		end
		rec_c.l2    = l2_c;
		rec_c.r     = dot_c[psd_pkg::L2_W-1:0];
		rec_c.t     = '0;
		rec_c.run   = 1'b0;
		rec_c.degen = (l2_c == '0);
		// t stays zero for degenerate segments and for dot <= 0
		if (!rec_c.degen && !dot_c[psd_pkg::DOT_W-1] && dot_c != '0) begin
			if (dot_c[psd_pkg::L2_W-1:0] >= l2_c)
				rec_c.t = psd_pkg::T_W'(1) << psd_pkg::T_FRAC_BITS;
			else
				rec_c.run = 1'b1;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = rec_s3;

endmodule

FILE: rtl/psd_div_cell.sv
// psd_div_cell: one restoring division step, one quotient bit of t per cell;
// depends on psd_pkg
module psd_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  psd_pkg::psd_div_t  in_data,
	output logic               in_ready,
	output logic               out_valid,
	output psd_pkg::psd_div_t  out_data,
	input  logic               out_ready
);

	logic              valid_q;
	psd_pkg::psd_div_t data_q;
	psd_pkg::psd_div_t next_c;
	logic [psd_pkg::L2_W:0] r2_c;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		next_c = in_data;
		r2_c   = {in_data.r, 1'b0};
		if (in_data.run) begin
			if (r2_c >= {1'b0, in_data.l2}) begin
				next_c.r = psd_pkg::L2_W'(r2_c - {1'b0, in_data.l2});
				next_c.t = {in_data.t[psd_pkg::T_W-2:0], 1'b1};
			end else begin
				next_c.r = r2_c[psd_pkg::L2_W-1:0];
				next_c.t = {in_data.t[psd_pkg::T_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) data_q <= next_c;
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

FILE: rtl/psd_proj.sv
// psd_proj: projection offset, error vector and squared distance,
// four stages; depends on psd_pkg
module psd_proj (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  psd_pkg::psd_div_t  in_data,
	output logic               in_ready,
	output logic               out_valid,
	output psd_pkg::psd_sqrt_t out_data,
	input  logic               out_ready
);

	localparam int OW = psd_pkg::OFFP_W;
	localparam int EW = psd_pkg::ERR_W;
	localparam int DW = psd_pkg::DIFF_W;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready_s1, ready_s2, ready_s3, ready_s4;
	logic degen_s1, degen_s2, degen_s3, degen_s4;

	logic signed [OW-1:0]   prod_s1 [3];
	logic signed [DW-1:0]   w_s1 [3];
	logic signed [EW-1:0]   e_s2 [3];
	logic signed [2*EW-1:0] ee_s3 [3];
	logic [psd_pkg::SQ_W-1:0] n_s4;

	logic [OW-1:0]        mag_c [3];
	logic signed [EW-1:0] off_c [3];
	logic [psd_pkg::SQ_W-1:0] n_c;

	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// offset rounds toward zero
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = prod_s1[i][OW-1] ? OW'(-prod_s1[i]) : OW'(prod_s1[i]);
			off_c[i] = $signed(EW'(mag_c[i] >> psd_pkg::T_FRAC_BITS));
			if (prod_s1[i][OW-1]) off_c[i] = -off_c[i];
		end
		n_c = '0;
		for (int i = 0; i < 3; i++)
			n_c = n_c + psd_pkg::SQ_W'($unsigned(ee_s3[i]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			degen_s1 <= in_data.degen;
			for (int i = 0; i < 3; i++) begin
				w_s1[i]    <= $signed(in_data.w[i]);
				prod_s1[i] <= OW'($signed({1'b0, in_data.t}) * $signed(in_data.d[i]));
			end
		end
		if (ready_s2 && valid_s1) begin
			degen_s2 <= degen_s1;
			for (int i = 0; i < 3; i++)
				e_s2[i] <= EW'(w_s1[i]) - off_c[i];
		end
		if (ready_s3 && valid_s2) begin
			degen_s3 <= degen_s2;
			for (int i = 0; i < 3; i++)
				ee_s3[i] <= e_s2[i] * e_s2[i];
		end
		if (ready_s4 && valid_s3) begin
			degen_s4 <= degen_s3;
			n_s4     <= n_c;
		end
	end

	assign out_valid      = valid_s4;
	assign out_data.n     = n_s4;
	assign out_data.rem   = '0;
	assign out_data.root  = '0;
	assign out_data.degen = degen_s4;

endmodule

FILE: rtl/psd_sqrt_cell.sv
// psd_sqrt_cell: one digit-by-digit square root step, one root bit per cell;
// depends on psd_pkg
module psd_sqrt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  psd_pkg::psd_sqrt_t in_data,
	output logic               in_ready,
	output logic               out_valid,
	output psd_pkg::psd_sqrt_t out_data,
	input  logic               out_ready
);

	localparam int RW = psd_pkg::REM_W;

	logic               valid_q;
	psd_pkg::psd_sqrt_t data_q;
	psd_pkg::psd_sqrt_t next_c;
	logic [RW+1:0]      acc_c;
	logic [RW+1:0]      trial_c;

	assign in_ready = !valid_q || out_ready;

	// bring down the next two bits, try root*4+1
	always_comb begin
		next_c  = in_data;
		acc_c   = {in_data.rem, in_data.n[psd_pkg::SQ_W-1 -: 2]};
		trial_c = (RW+2)'({in_data.root, 2'b01});
		next_c.n = {in_data.n[psd_pkg::SQ_W-3:0], 2'b00};
		if (acc_c >= trial_c) begin
			next_c.rem  = RW'(acc_c - trial_c);
			next_c.root = {in_data.root[psd_pkg::ROOT_W-2:0], 1'b1};
		end else begin
			next_c.rem  = acc_c[RW-1:0];
			next_c.root = {in_data.root[psd_pkg::ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) data_q <= next_c;
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

FILE: rtl/point_segment_distance_3d_top.sv
// point_segment_distance_3d_top: distance from a point to a 3d segment,
// chains front stages, divider cells, projection and square root cells
// depends on psd_pkg, psd_front, psd_div_cell, psd_proj, psd_sqrt_cell
//
// usage:
//   pts carries one query (endpoints a, b and point p, signed Q15.8) per
//   beat, taken when pts_valid is high and pts_stall low. res carries the
//   floor distance (Q.8) and the degenerate flag, taken when res_valid is
//   high and res_stall low.
//   the chain is 3 front stages, 16 divider cells (one bit of t each),
//   4 projection stages, 27 square root cells (one root bit each) and the
//   output register. one beat per cycle is taken and delivered while res_stall is low.
//   every stage holds its beat while the next one is full and stalled, so
//   a stall at res fills empty stages first and reaches pts_stall only when
//   the whole chain is full; the chain holds up to 51 beats.
//   reset empties every stage; nothing else is kept between beats.
module point_segment_distance_3d_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pts_valid,
	output logic               pts_stall,
	input  psd_pkg::psd_in_t   pts,
	output logic               res_valid,
	input  logic               res_stall,
	output psd_pkg::psd_out_t  res
);

	localparam int NDIV  = psd_pkg::T_FRAC_BITS;
	localparam int NSQRT = psd_pkg::ROOT_W;

	logic              div_valid [NDIV+1];
	logic              div_ready [NDIV+1];
	psd_pkg::psd_div_t div_data  [NDIV+1];

	logic               sq_valid [NSQRT+1];
	logic               sq_ready [NSQRT+1];
	psd_pkg::psd_sqrt_t sq_data  [NSQRT+1];

	logic              front_ready;
	logic              res_valid_q;
	psd_pkg::psd_out_t res_q;
	logic              out_ready;

	psd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pts_valid),
		.in_data   (pts),
		.in_ready  (front_ready),
		.out_valid (div_valid[0]),
		.out_data  (div_data[0]),
		.out_ready (div_ready[0])
	);

	for (genvar g = 0; g < NDIV; g++) begin : g_div
		psd_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (div_valid[g]),
			.in_data   (div_data[g]),
			.in_ready  (div_ready[g]),
			.out_valid (div_valid[g+1]),
			.out_data  (div_data[g+1]),
			.out_ready (div_ready[g+1])
		);
	end

	psd_proj u_proj (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid[NDIV]),
		.in_data   (div_data[NDIV]),
		.in_ready  (div_ready[NDIV]),
		.out_valid (sq_valid[0]),
		.out_data  (sq_data[0]),
		.out_ready (sq_ready[0])
	);

	for (genvar g = 0; g < NSQRT; g++) begin : g_sqrt
		psd_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (sq_valid[g]),
			.in_data   (sq_data[g]),
			.in_ready  (sq_ready[g]),
			.out_valid (sq_valid[g+1]),
			.out_data  (sq_data[g+1]),
			.out_ready (sq_ready[g+1])
		);
	end

	assign out_ready       = !res_valid_q || !res_stall;
	assign sq_ready[NSQRT] = out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_ready) begin
			res_valid_q <= sq_valid[NSQRT];
		end
	end

	// saturate the root to the result width
	always_ff @(posedge clk) begin
		if (out_ready && sq_valid[NSQRT]) begin
			res_q.degenerate <= sq_data[NSQRT].degen;
			if (sq_data[NSQRT].root[psd_pkg::ROOT_W-1:psd_pkg::DIST_W] != '0)
				res_q.distance <= '1;
			else
				res_q.distance <= sq_data[NSQRT].root[psd_pkg::DIST_W-1:0];
		end
	end

	assign pts_stall = !front_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// a draining output frees every stage back to the input
	a_drain_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall) |-> !pts_stall)
		else $error("input stalled while the output drains");

	// t never exceeds one
	a_t_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid[NDIV] |->
		(div_data[NDIV].t <= (psd_pkg::T_W'(1) << psd_pkg::T_FRAC_BITS)))
		else $error("projection parameter above one");

	// degenerate segments never run the divider
	a_degen_t_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(div_valid[NDIV] && div_data[NDIV].degen) |->
		(div_data[NDIV].t == '0 && !div_data[NDIV].run))
		else $error("degenerate segment with nonzero t");

endmodule
